### hw/rtl/sacr_pkg.sv
// ----------------------------------------------------------------------------
// sacr_pkg
// Shared types, constants and helpers for the random-replacement cache
// tag store.
// ----------------------------------------------------------------------------
package sacr_pkg;

    // default geometry
    localparam int SETS_DEF = 256;
    localparam int WAYS_DEF = 4;

    // address and tag widths
    localparam int ADDR_W = 32;
    localparam int TAG_W  = 32;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 4'd1;
    localparam logic [CFG_DAT_W-1:0] OFFSET_BITS_RST = 4'd5;
    localparam logic [CFG_DAT_W-1:0] INDEX_BITS_RST  = 4'd6;

    // remainder unit: dividend width and step counter width
    localparam int DIVD_W = 16;
    localparam int STEP_W = $clog2(DIVD_W);

    // random source
    localparam int          LFSR_W    = 16;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // output way field
    localparam int WAY_OUT_W = 2;
    localparam int CNT_W     = 32;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_SET,
        ST_SET_REM,
        ST_READ,
        ST_CMP,
        ST_MOD_WAY,
        ST_SCAN,
        ST_WRITE
    } t_state;

    // one galois step: shift right, fold taps in when a one drops out
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] v;
        v = s >> 1;
        if (s[0]) begin
            v = v ^ LFSR_TAPS;
        end
        return v;
    endfunction

endpackage

### hw/rtl/sacr_rem_unit.sv
// ----------------------------------------------------------------------------
// sacr_rem_unit
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sacr_rem_unit #(
    parameter int DIV_W = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [sacr_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [DIV_W-1:0]              i_divisor,
    output logic                          o_done,
    output logic [DIV_W-1:0]              o_rem
);

    logic [sacr_pkg::DIVD_W-1:0] r_dvd;
    logic [DIV_W-1:0]            r_div;
    logic [DIV_W-1:0]            r_rem;
    logic [sacr_pkg::STEP_W-1:0] r_cnt;
    logic                        r_run;
    logic                        r_done;
    logic [DIV_W:0]              w_trial;
    logic [DIV_W:0]              w_next;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[sacr_pkg::DIVD_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            w_next = w_trial - {1'b0, r_div};
        end else begin
            w_next = w_trial;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_load) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == {sacr_pkg::STEP_W{1'b1}}) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_next[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hw/rtl/sacr_tag_ram.sv
// ----------------------------------------------------------------------------
// sacr_tag_ram
// Row-wide tag and valid memories, one row per set, registered read.
// ----------------------------------------------------------------------------
module sacr_tag_ram #(
    parameter int SETS = sacr_pkg::SETS_DEF,
    parameter int WAYS = sacr_pkg::WAYS_DEF,
    parameter int SIW  = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rd_en,
    input  logic [SIW-1:0]                         i_rd_addr,
    input  logic                                   i_wr_en,
    input  logic [SIW-1:0]                         i_wr_addr,
    input  logic [WAYS-1:0][sacr_pkg::TAG_W-1:0]   i_wr_tags,
    input  logic [WAYS-1:0]                        i_wr_vld,
    output logic [WAYS-1:0][sacr_pkg::TAG_W-1:0]   o_rd_tags,
    output logic [WAYS-1:0]                        o_rd_vld
);

    logic [WAYS-1:0][sacr_pkg::TAG_W-1:0] r_tag_mem [SETS];
    logic [WAYS-1:0]                      r_vld_mem [SETS];
    logic [WAYS-1:0][sacr_pkg::TAG_W-1:0] r_rd_tags;
    logic [WAYS-1:0]                      r_rd_vld;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tag_mem[i_wr_addr] <= i_wr_tags;
            r_vld_mem[i_wr_addr] <= i_wr_vld;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tags <= r_tag_mem[i_rd_addr];
            r_rd_vld  <= r_vld_mem[i_rd_addr];
        end
    end

    assign o_rd_tags = r_rd_tags;
    assign o_rd_vld  = r_rd_vld;

endmodule

### hw/rtl/set_assoc_cache_random_replace_core.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_random_replace_core
// Tag store of a set-associative cache with random victim selection.
//
// channel   direction  handshake                     payload
// lookup    in         start high, busy low          i_address
// result    out        o_valid, one cycle, no stall  o_hit, o_way_used,
//                                                    o_hit_total, o_miss_total
// config    in         i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// A hit keeps busy high through ST_MOD_SET, ST_SET_REM, ST_READ and ST_CMP,
// so a new lookup is taken only once the last one is reported. A miss goes on
// through ST_MOD_WAY, then ST_SCAN when the set still has a free way, and ST_WRITE.
// The set index is reduced modulo SETS by a reciprocal multiply in ST_MOD_SET
// and ST_SET_REM; on a miss the bit-serial remainder unit turns the new 16-bit
// lfsr value into a way pick.
// After reset a clearing pass zeroes every valid row; busy
// stays high through it, config beats are taken throughout.
// The result receiver cannot stall; o_valid lasts one cycle.
// ----------------------------------------------------------------------------
module set_assoc_cache_random_replace_core #(
    parameter int SETS = sacr_pkg::SETS_DEF,
    parameter int WAYS = sacr_pkg::WAYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sacr_pkg::ADDR_W-1:0]        i_address,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic [sacr_pkg::WAY_OUT_W-1:0]     o_way_used,
    output logic [sacr_pkg::CNT_W-1:0]         o_hit_total,
    output logic [sacr_pkg::CNT_W-1:0]         o_miss_total,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sacr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sacr_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int SIW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DVW    = $clog2(WAYS + 1);
    localparam int TAG_W  = sacr_pkg::TAG_W;
    localparam int SHA_W  = sacr_pkg::CFG_DAT_W + 1;
    // reciprocal of SETS, exact for any index below 2**DIVD_W
    localparam int RCP_SH = sacr_pkg::DIVD_W + $clog2(SETS);
    localparam int RCP_W  = sacr_pkg::DIVD_W + 1;
    localparam int RCP_M  = ((1 << RCP_SH) + SETS - 1) / SETS;
    localparam int PRD_W  = sacr_pkg::DIVD_W + RCP_W;

    // state
    sacr_pkg::t_state             r_state, n_state;
    logic [sacr_pkg::CFG_DAT_W-1:0] r_offset_bits, r_index_bits;
    logic [TAG_W-1:0]             r_tag, n_tag;
    logic [sacr_pkg::DIVD_W-1:0]  r_idx, n_idx;
    logic [sacr_pkg::DIVD_W-1:0]  r_quo, n_quo;
    logic [SIW-1:0]               r_set, n_set;
    logic [SIW-1:0]               r_clr_idx, n_clr_idx;
    logic [WAYS-1:0]              r_hitv, n_hitv;
    logic [WAYS-1:0]              r_inv, n_inv;
    logic [DVW-1:0]               r_pick, n_pick;
    logic [WW-1:0]                r_scan_w, n_scan_w;
    logic [DVW-1:0]               r_scan_cnt, n_scan_cnt;
    logic [WW-1:0]                r_victim, n_victim;
    logic [sacr_pkg::LFSR_W-1:0]  r_lfsr, n_lfsr;
    logic [sacr_pkg::CNT_W-1:0]   r_hit_cnt, n_hit_cnt;
    logic [sacr_pkg::CNT_W-1:0]   r_miss_cnt, n_miss_cnt;
    logic                         r_valid, n_valid;
    logic                         r_hit, n_hit;
    logic [sacr_pkg::WAY_OUT_W-1:0] r_way, n_way;

    // remainder unit and memory hookup
    logic                         w_rem_load;
    logic [sacr_pkg::DIVD_W-1:0]  w_rem_dvd;
    logic [DVW-1:0]               w_rem_div;
    logic                         w_rem_done;
    logic [DVW-1:0]               w_rem;
    logic                         w_rd_en;
    logic [SIW-1:0]               w_rd_addr;
    logic                         w_wr_en;
    logic [SIW-1:0]               w_wr_addr;
    logic [WAYS-1:0][TAG_W-1:0]   w_wr_tags;
    logic [WAYS-1:0]              w_wr_vld;
    logic [WAYS-1:0][TAG_W-1:0]   w_rd_tags;
    logic [WAYS-1:0]              w_rd_vld;

    // address split
    logic [SHA_W-1:0]             w_shamt;
    logic [TAG_W-1:0]             w_addr_tag;
    logic [sacr_pkg::DIVD_W:0]    w_idx_mask;
    logic [sacr_pkg::DIVD_W-1:0]  w_addr_idx;
    logic [sacr_pkg::ADDR_W-1:0]  w_addr_sh;
    logic [WW-1:0]                w_hit_way;

    // set index reduction
    logic [PRD_W-1:0]             w_quo_prod;
    logic [sacr_pkg::DIVD_W-1:0]  w_quo_sets;
    logic [sacr_pkg::DIVD_W-1:0]  w_set_rem;

    assign w_shamt    = SHA_W'(r_offset_bits) + SHA_W'(r_index_bits);
    assign w_addr_tag = i_address >> w_shamt;
    assign w_addr_sh  = i_address >> r_offset_bits;
    assign w_idx_mask = (sacr_pkg::DIVD_W+1)'((sacr_pkg::DIVD_W+1)'(1) << r_index_bits) - 1'b1;
    assign w_addr_idx = w_addr_sh[sacr_pkg::DIVD_W-1:0] & w_idx_mask[sacr_pkg::DIVD_W-1:0];

    // quotient by reciprocal multiply, remainder by multiply and subtract
    assign w_quo_prod = PRD_W'(r_idx) * PRD_W'(RCP_M);
    assign w_quo_sets = r_quo * sacr_pkg::DIVD_W'(SETS);
    assign w_set_rem  = r_idx - w_quo_sets;

    // lowest matching way
    always_comb begin
        w_hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_hitv[w]) begin
                w_hit_way = WW'(w);
            end
        end
    end

    sacr_rem_unit #(
        .DIV_W (DVW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_rem_load),
        .i_dividend (w_rem_dvd),
        .i_divisor  (w_rem_div),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    sacr_tag_ram #(
        .SETS (SETS),
        .WAYS (WAYS),
        .SIW  (SIW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_tags (w_wr_tags),
        .i_wr_vld  (w_wr_vld),
        .o_rd_tags (w_rd_tags),
        .o_rd_vld  (w_rd_vld)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= sacr_pkg::OFFSET_BITS_RST;
            r_index_bits  <= sacr_pkg::INDEX_BITS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sacr_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data;
                sacr_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sacr_pkg::ST_CLEAR;
            r_clr_idx  <= '0;
            r_lfsr     <= sacr_pkg::LFSR_SEED;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_idx  <= n_clr_idx;
            r_lfsr     <= n_lfsr;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            r_valid    <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_tag      <= n_tag;
        r_idx      <= n_idx;
        r_quo      <= n_quo;
        r_set      <= n_set;
        r_hitv     <= n_hitv;
        r_inv      <= n_inv;
        r_pick     <= n_pick;
        r_scan_w   <= n_scan_w;
        r_scan_cnt <= n_scan_cnt;
        r_victim   <= n_victim;
        r_hit      <= n_hit;
        r_way      <= n_way;
    end

    // sequencer: next state and datapath controls
    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_lfsr     = r_lfsr;
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        n_valid    = 1'b0;
        n_tag      = r_tag;
        n_idx      = r_idx;
        n_quo      = r_quo;
        n_set      = r_set;
        n_hitv     = r_hitv;
        n_inv      = r_inv;
        n_pick     = r_pick;
        n_scan_w   = r_scan_w;
        n_scan_cnt = r_scan_cnt;
        n_victim   = r_victim;
        n_hit      = r_hit;
        n_way      = r_way;
        w_rem_load = 1'b0;
        w_rem_dvd  = '0;
        w_rem_div  = '0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_set;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_set;
        w_wr_tags  = w_rd_tags;
        w_wr_vld   = w_rd_vld;

        case (r_state)
            // zero one valid row per cycle
            sacr_pkg::ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_idx;
                w_wr_vld  = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == SIW'(SETS - 1)) begin
                    n_state = sacr_pkg::ST_IDLE;
                end
            end
            // take a lookup beat, hold its tag and raw index
            sacr_pkg::ST_IDLE: begin
                if (start) begin
                    n_tag   = w_addr_tag;
                    n_idx   = w_addr_idx;
                    n_state = sacr_pkg::ST_MOD_SET;
                end
            end
            // quotient of the index by SETS
            sacr_pkg::ST_MOD_SET: begin
                n_quo   = sacr_pkg::DIVD_W'(w_quo_prod >> RCP_SH);
                n_state = sacr_pkg::ST_SET_REM;
            end
            // set index ready, read the row
            sacr_pkg::ST_SET_REM: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_set_rem[SIW-1:0];
                n_set     = w_set_rem[SIW-1:0];
                n_state   = sacr_pkg::ST_READ;
            end
            // compare every way of the row
            sacr_pkg::ST_READ: begin
                for (int w = 0; w < WAYS; w++) begin
                    n_hitv[w] = w_rd_vld[w] && (w_rd_tags[w] == r_tag);
                end
                n_inv   = ~w_rd_vld;
                n_state = sacr_pkg::ST_CMP;
            end
            // hit: report; miss: step the lfsr and reduce it
            sacr_pkg::ST_CMP: begin
                if (r_hitv != '0) begin
                    n_hit     = 1'b1;
                    n_way     = sacr_pkg::WAY_OUT_W'(w_hit_way);
                    n_hit_cnt = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + 1'b1;
                    n_valid   = 1'b1;
                    n_state   = sacr_pkg::ST_IDLE;
                end else begin
                    n_lfsr     = sacr_pkg::lfsr_step(r_lfsr);
                    w_rem_load = 1'b1;
                    w_rem_dvd  = sacr_pkg::lfsr_step(r_lfsr);
                    w_rem_div  = (r_inv == '0) ? DVW'(WAYS) : DVW'($countones(r_inv));
                    n_state    = sacr_pkg::ST_MOD_WAY;
                end
            end
            // pick index ready
            sacr_pkg::ST_MOD_WAY: begin
                if (w_rem_done) begin
                    n_pick = w_rem;
                    if (r_inv == '0) begin
                        n_victim = w_rem[WW-1:0];
                        n_state  = sacr_pkg::ST_WRITE;
                    end else begin
                        n_scan_w   = '0;
                        n_scan_cnt = '0;
                        n_state    = sacr_pkg::ST_SCAN;
                    end
                end
            end
            // walk ways to the pick-th invalid one
            sacr_pkg::ST_SCAN: begin
                n_scan_w = r_scan_w + 1'b1;
                if (r_inv[r_scan_w]) begin
                    if (r_scan_cnt == r_pick) begin
                        n_victim = r_scan_w;
                        n_state  = sacr_pkg::ST_WRITE;
                    end else begin
                        n_scan_cnt = r_scan_cnt + 1'b1;
                    end
                end
            end
            // fill the victim and report the miss
            sacr_pkg::ST_WRITE: begin
                w_wr_en             = 1'b1;
                w_wr_tags[r_victim] = r_tag;
                w_wr_vld[r_victim]  = 1'b1;
                n_hit      = 1'b0;
                n_way      = sacr_pkg::WAY_OUT_W'(r_victim);
                n_miss_cnt = (r_miss_cnt == '1) ? r_miss_cnt : r_miss_cnt + 1'b1;
                n_valid    = 1'b1;
                n_state    = sacr_pkg::ST_IDLE;
            end
            default: begin
                n_state = sacr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy         = (r_state != sacr_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_way_used   = r_way;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;
    assign o_cfg_ready  = 1'b1;

endmodule

### hw/rtl/sacr_checker.sv
// ----------------------------------------------------------------------------
// sacr_checker
// Port-level checks on the cache tag store, bound to the top level.
// ----------------------------------------------------------------------------
module sacr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic                             o_hit,
    input logic [sacr_pkg::CNT_W-1:0]       o_hit_total,
    input logic [sacr_pkg::CNT_W-1:0]       o_miss_total
);

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepted lookup");

    // a result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a result is only shown once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // counters include the reported access
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_hit_total != '0)
        else $error("hit reported with zero hit total");

    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_miss_total != '0)
        else $error("miss reported with zero miss total");

endmodule

bind set_assoc_cache_random_replace_core sacr_checker u_sacr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_hit        (o_hit),
    .o_hit_total  (o_hit_total),
    .o_miss_total (o_miss_total)
);
